[sv/lvse_pkg.sv]
// ----------------------------------------------------------------------------
// lvse_pkg
// Shared types, constants and the reciprocal ROM of the Legendre evaluator.
// ----------------------------------------------------------------------------
package lvse_pkg;

   localparam int LVSE_MAX_ORDER_DEF = 32;

   // width of the recurrence registers: holds +-2^52
   localparam int WIDE_W = 54;

   localparam int CSR_IDXW = 2;
   localparam int CSR_DATAW = 32;
   localparam int ORDER_W = 6;

   localparam logic [CSR_IDXW-1:0] CSR_POLY_ORDER  = 2'd0;
   localparam logic [CSR_IDXW-1:0] CSR_DILATION    = 2'd1;
   localparam logic [CSR_IDXW-1:0] CSR_TRANSLATION = 2'd2;

   localparam logic [WIDE_W-1:0] LIM52_MAG = 54'd4503599627370496;
   localparam logic signed [WIDE_W-1:0] ONE_Q30 = 54'sd1073741824;
   localparam logic signed [WIDE_W-1:0] ONE_Q32 = 54'sd4294967296;

   // reciprocal ROM: entry j holds round(2^32 / (j+1))
   localparam int RCP_IDXW = 6;
   localparam int RCP_W = 33;
   localparam logic [34:0] RCP_TWO33 = 35'h2_0000_0000;
   localparam logic [RCP_W-1:0] RCP_TABLE [0:63] = '{
      33'(((RCP_TWO33 / 35'd1) + 35'd1) >> 1),  33'(((RCP_TWO33 / 35'd2) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd3) + 35'd1) >> 1),  33'(((RCP_TWO33 / 35'd4) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd5) + 35'd1) >> 1),  33'(((RCP_TWO33 / 35'd6) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd7) + 35'd1) >> 1),  33'(((RCP_TWO33 / 35'd8) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd9) + 35'd1) >> 1),  33'(((RCP_TWO33 / 35'd10) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd11) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd12) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd13) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd14) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd15) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd16) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd17) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd18) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd19) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd20) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd21) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd22) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd23) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd24) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd25) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd26) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd27) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd28) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd29) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd30) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd31) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd32) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd33) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd34) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd35) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd36) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd37) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd38) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd39) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd40) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd41) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd42) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd43) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd44) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd45) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd46) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd47) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd48) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd49) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd50) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd51) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd52) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd53) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd54) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd55) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd56) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd57) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd58) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd59) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd60) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd61) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd62) + 35'd1) >> 1),
      33'(((RCP_TWO33 / 35'd63) + 35'd1) >> 1), 33'(((RCP_TWO33 / 35'd64) + 35'd1) >> 1)
   };

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MAP,
      SEQ_CHECK,
      SEQ_STEP,
      SEQ_WAIT_T,
      SEQ_WAIT_U,
      SEQ_COMB_D,
      SEQ_WAIT_Y,
      SEQ_WAIT_D,
      SEQ_OUT
   } lvse_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LO,
      MUL_HI,
      MUL_FIN
   } lvse_phase_type;

   typedef struct packed {
      logic                     start;
      logic                     sh32;
      logic signed [WIDE_W-1:0] a;
      logic signed [WIDE_W-1:0] b;
   } lvse_mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [WIDE_W-1:0] product;
   } lvse_mul_rsp_type;

   typedef struct packed {
      logic [ORDER_W-1:0]         poly_order;
      logic signed [CSR_DATAW-1:0] dilation;
      logic signed [CSR_DATAW-1:0] translation;
   } lvse_cfg_type;

   typedef struct packed {
      logic               out_of_range;
      logic signed [47:0] poly_slope;
      logic signed [31:0] poly_value;
   } lvse_result_type;

endpackage

[sv/lvse_mul_unit.sv]
// ----------------------------------------------------------------------------
// lvse_mul_unit
// Shared rounding multiplier: round(a*b / 2^sh), ties away from zero, with
// |b| limited to 2^32 and the result limited to +-2^52. One 32x33 multiplier
// runs two partial products, then a final round, limit and sign step.
// ----------------------------------------------------------------------------
module lvse_mul_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  lvse_pkg::lvse_mul_req_type mul_req,
   output lvse_pkg::lvse_mul_rsp_type mul_rsp
);
   import lvse_pkg::*;

   localparam int HIW = WIDE_W - 32;
   localparam int SUMW = 32 + HIW + 34;

   lvse_phase_type           phase_ff, phase_in;
   logic                     neg_ff, neg_in;
   logic                     sh32_ff, sh32_in;
   logic [WIDE_W-1:0]        ma_ff, ma_in;
   logic [32:0]              mb_ff, mb_in;
   logic [64:0]              p_lo_ff, p_lo_in;
   logic [HIW+32:0]          p_hi_ff, p_hi_in;
   logic                     done_ff, done_in;
   logic signed [WIDE_W-1:0] result_ff, result_in;

   logic [WIDE_W-1:0] abs_a;
   logic [WIDE_W-1:0] abs_b;
   logic [31:0]       mul_a;
   logic [64:0]       mul_p;
   logic [SUMW-1:0]   sum;
   logic [SUMW-1:0]   shifted;
   logic [WIDE_W-1:0] mag;

   always_comb begin
      abs_a = mul_req.a[WIDE_W-1] ? WIDE_W'(-mul_req.a) : WIDE_W'(mul_req.a);
      abs_b = mul_req.b[WIDE_W-1] ? WIDE_W'(-mul_req.b) : WIDE_W'(mul_req.b);
      mul_a = (phase_ff == MUL_LO) ? ma_ff[31:0] : 32'(ma_ff[WIDE_W-1:32]);
      mul_p = 65'(mul_a) * 65'(mb_ff);
      sum = (SUMW'(p_hi_ff) << 32) + SUMW'(p_lo_ff)
            + (sh32_ff ? (SUMW'(1) << 31) : (SUMW'(1) << 29));
      shifted = sh32_ff ? (sum >> 32) : (sum >> 30);
      mag = (shifted > SUMW'(LIM52_MAG)) ? LIM52_MAG : shifted[WIDE_W-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      neg_in = neg_ff;
      sh32_in = sh32_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      p_lo_in = p_lo_ff;
      p_hi_in = p_hi_ff;
      result_in = result_ff;
      done_in = (phase_ff == MUL_FIN);
      unique case (phase_ff)
         MUL_IDLE: begin
            if (mul_req.start) begin
               neg_in = mul_req.a[WIDE_W-1] ^ mul_req.b[WIDE_W-1];
               sh32_in = mul_req.sh32;
               ma_in = abs_a;
               mb_in = (abs_b > (WIDE_W'(1) << 32)) ? (33'(1) << 32) : abs_b[32:0];
               phase_in = MUL_LO;
            end
         end
         MUL_LO: begin
            p_lo_in = mul_p;
            phase_in = MUL_HI;
         end
         MUL_HI: begin
            p_hi_in = (HIW+33)'(mul_p);
            phase_in = MUL_FIN;
         end
         MUL_FIN: begin
            result_in = neg_ff ? -$signed(mag) : $signed(mag);
            phase_in = MUL_IDLE;
         end
         default: phase_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MUL_IDLE;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      sh32_ff <= sh32_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      p_lo_ff <= p_lo_in;
      p_hi_ff <= p_hi_in;
      result_ff <= result_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.product = result_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> (phase_ff == MUL_IDLE))
      else $error("multiply started while unit busy");

   a_result_limited: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ((result_ff <= $signed(LIM52_MAG)) && (result_ff >= -$signed(LIM52_MAG))))
      else $error("multiply result beyond limit");

endmodule

[sv/lvse_sequencer.sv]
// ----------------------------------------------------------------------------
// lvse_sequencer
// Maps the sample point, checks its range and steps the three-term
// recurrence for value and slope, issuing the four rounded products of each step to the shared unit.
// ----------------------------------------------------------------------------
module lvse_sequencer #(
   parameter int MAX_ORDER = lvse_pkg::LVSE_MAX_ORDER_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [31:0]         sample_x,
   input  lvse_pkg::lvse_cfg_type     cfg,
   output logic                       res_valid,
   input  logic                       res_ready,
   output lvse_pkg::lvse_result_type  result,
   output lvse_pkg::lvse_mul_req_type mul_req,
   input  lvse_pkg::lvse_mul_rsp_type mul_rsp
);
   import lvse_pkg::*;

   localparam int IW = $clog2(MAX_ORDER + 1);
   localparam logic signed [63:0] LIM64 = 64'sd4503599627370496;
   localparam logic signed [65:0] QF_ONE = 66'sd4294967296;

   lvse_state_type           state_ff, state_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [31:0]       q_ff, q_in;
   logic signed [WIDE_W-1:0] y_ff, y_in;
   logic signed [WIDE_W-1:0] yp_ff, yp_in;
   logic signed [WIDE_W-1:0] dy_ff, dy_in;
   logic signed [WIDE_W-1:0] dyp_ff, dyp_in;
   logic signed [WIDE_W-1:0] t_ff, t_in;
   logic signed [WIDE_W-1:0] u_ff, u_in;
   logic signed [WIDE_W-1:0] nv_ff, nv_in;
   logic signed [WIDE_W-1:0] nd_ff, nd_in;
   logic signed [WIDE_W-1:0] ynew_ff, ynew_in;
   logic [IW-1:0]            i_ff, i_in;
   logic [IW-1:0]            order_ff, order_in;
   logic                     oor_ff, oor_in;

   logic signed [65:0]       qf;
   logic                     qf_out;
   logic signed [31:0]       q_val;
   logic [7:0]               ord_req;
   logic [IW-1:0]            ord_eff;
   logic [IW:0]              c2;
   logic [IW-1:0]            c4;
   logic signed [63:0]       c2_s;
   logic signed [63:0]       c4_s;
   logic signed [63:0]       nv_sum;
   logic signed [63:0]       nd_sum;
   logic [RCP_IDXW:0]        i_wide;
   logic [RCP_IDXW-1:0]      rcp_idx;
   logic [RCP_W-1:0]         rcp;
   logic signed [WIDE_W-1:0] rcp_s;

   function automatic logic signed [WIDE_W-1:0] clamp52(input logic signed [63:0] v);
      logic signed [WIDE_W-1:0] r;
      if (v > LIM64) begin
         r = WIDE_W'(LIM64);
      end else if (v < -LIM64) begin
         r = WIDE_W'(-LIM64);
      end else begin
         r = WIDE_W'(v);
      end
      return r;
   endfunction

   always_comb begin
      qf = 66'(prod_ff) + (66'(cfg.translation) <<< 16);
      qf_out = (qf > QF_ONE) || (qf < -QF_ONE);
      q_val = 32'(qf >>> 2);
      ord_req = 8'(cfg.poly_order);
      ord_eff = (ord_req > 8'(MAX_ORDER)) ? IW'(MAX_ORDER) : IW'(ord_req);
      c2 = (IW+1)'({i_ff, 1'b0}) - 1'b1;
      c4 = i_ff - 1'b1;
      c2_s = 64'($signed({1'b0, c2}));
      c4_s = 64'($signed({1'b0, c4}));
      nv_sum = c2_s * 64'(t_ff) - c4_s * 64'(yp_ff);
      nd_sum = c2_s * (64'(u_ff) + (64'(y_ff) <<< 2)) - c4_s * 64'(dyp_ff);
      i_wide = (RCP_IDXW+1)'(i_ff);
      rcp_idx = RCP_IDXW'(i_wide - 1'b1);
      rcp = RCP_TABLE[rcp_idx];
      rcp_s = $signed(WIDE_W'(rcp));
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      y_in = y_ff;
      yp_in = yp_ff;
      dy_in = dy_ff;
      dyp_in = dyp_ff;
      t_in = t_ff;
      u_in = u_ff;
      nv_in = nv_ff;
      nd_in = nd_ff;
      ynew_in = ynew_ff;
      i_in = i_ff;
      order_in = order_ff;
      oor_in = oor_ff;
      in_ready = 1'b0;
      res_valid = 1'b0;
      mul_req = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               x_in = sample_x;
               state_in = SEQ_MAP;
            end
         end
         SEQ_MAP: begin
            prod_in = 64'(cfg.dilation) * 64'(x_ff);
            state_in = SEQ_CHECK;
         end
         SEQ_CHECK: begin
            q_in = q_val;
            order_in = ord_eff;
            oor_in = qf_out;
            i_in = IW'(2);
            yp_in = ONE_Q30;
            dyp_in = '0;
            if (qf_out) begin
               y_in = '0;
               dy_in = '0;
               state_in = SEQ_OUT;
            end else if (ord_eff == '0) begin
               y_in = ONE_Q30;
               dy_in = '0;
               state_in = SEQ_OUT;
            end else begin
               y_in = WIDE_W'(q_val);
               dy_in = ONE_Q32;
               state_in = (ord_eff == IW'(1)) ? SEQ_OUT : SEQ_STEP;
            end
         end
         SEQ_STEP: begin
            mul_req.start = 1'b1;
            mul_req.a = WIDE_W'(q_ff);
            mul_req.b = y_ff;
            state_in = SEQ_WAIT_T;
         end
         SEQ_WAIT_T: begin
            if (mul_rsp.done) begin
               t_in = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.a = dy_ff;
               mul_req.b = WIDE_W'(q_ff);
               state_in = SEQ_WAIT_U;
            end
         end
         SEQ_WAIT_U: begin
            nv_in = clamp52(nv_sum);
            if (mul_rsp.done) begin
               u_in = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.sh32 = 1'b1;
               mul_req.a = nv_ff;
               mul_req.b = rcp_s;
               state_in = SEQ_COMB_D;
            end
         end
         SEQ_COMB_D: begin
            nd_in = clamp52(nd_sum);
            state_in = SEQ_WAIT_Y;
         end
         SEQ_WAIT_Y: begin
            if (mul_rsp.done) begin
               ynew_in = mul_rsp.product;
               mul_req.start = 1'b1;
               mul_req.sh32 = 1'b1;
               mul_req.a = nd_ff;
               mul_req.b = rcp_s;
               state_in = SEQ_WAIT_D;
            end
         end
         SEQ_WAIT_D: begin
            if (mul_rsp.done) begin
               yp_in = y_ff;
               y_in = ynew_ff;
               dyp_in = dy_ff;
               dy_in = mul_rsp.product;
               if (i_ff == order_ff) begin
                  state_in = SEQ_OUT;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = SEQ_STEP;
               end
            end
         end
         SEQ_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      result.out_of_range = oor_ff;
      if (y_ff > 54'sd2147483647) begin
         result.poly_value = 32'sh7FFF_FFFF;
      end else if (y_ff < -54'sd2147483648) begin
         result.poly_value = 32'sh8000_0000;
      end else begin
         result.poly_value = y_ff[31:0];
      end
      if (dy_ff > 54'sd140737488355327) begin
         result.poly_slope = 48'sh7FFF_FFFF_FFFF;
      end else if (dy_ff < -54'sd140737488355328) begin
         result.poly_slope = 48'sh8000_0000_0000;
      end else begin
         result.poly_slope = dy_ff[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      y_ff <= y_in;
      yp_ff <= yp_in;
      dy_ff <= dy_in;
      dyp_ff <= dyp_in;
      t_ff <= t_in;
      u_ff <= u_in;
      nv_ff <= nv_in;
      nd_ff <= nd_in;
      ynew_ff <= ynew_in;
      i_ff <= i_in;
      order_ff <= order_in;
      oor_ff <= oor_in;
   end

   a_done_awaited: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> ((state_ff == SEQ_WAIT_T) || (state_ff == SEQ_WAIT_U) ||
                        (state_ff == SEQ_WAIT_Y) || (state_ff == SEQ_WAIT_D)))
      else $error("product returned outside a wait state");

   a_step_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_STEP) |-> ((i_ff >= IW'(2)) && (i_ff <= order_ff)))
      else $error("recurrence index out of range");

endmodule

[sv/legendre_value_and_slope_eval.sv]
// ----------------------------------------------------------------------------
// legendre_value_and_slope_eval
// Evaluates P_k(q) and dP_k/dq at q = dilation*x + translation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample point per transaction (Q16.16). rsp_* returns
//   P_k in Q2.30 and its slope in Q16.32, saturated; rsp_tuser flags a
//   mapped point outside [-1,1], with both values then zero.
//   csr_* writes poly_order, dilation and translation; the user must do so
//   while the block idles, as the block itself does not enforce it. For
//   order 0 or 1 or a point out of range no recurrence step runs, else k-1
//   steps run. Each step issues four products to the shared 32x33
//   multiplier, each as two partial products plus a rounding step.
//   One point is in work at a time; req_tready rises in the same cycle as
//   rsp_tvalid.
//   The output register holds a result while rsp_tready is low; a finished
//   result then waits in the sequencer and no new point is taken.
//   Orders above MAX_ORDER are clamped to MAX_ORDER.
//   Reset clears the registers to order 0, dilation 1.0, translation 0 and
//   drops any point in work.
// ----------------------------------------------------------------------------
module legendre_value_and_slope_eval #(
   parameter int MAX_ORDER = lvse_pkg::LVSE_MAX_ORDER_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] sample_x
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [79:0]                    rsp_tdata,   // [31:0] poly_value, [79:32] poly_slope
   output logic [0:0]                     rsp_tuser,   // [0] out_of_range
   input  logic                           csr_wr_en,
   input  logic [lvse_pkg::CSR_IDXW-1:0]  csr_index,
   input  logic [lvse_pkg::CSR_DATAW-1:0] csr_wr_data
);
   import lvse_pkg::*;

   lvse_cfg_type     cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lvse_result_type  rsp_data_ff, rsp_data_in;

   lvse_result_type  seq_result;
   logic             seq_res_valid;
   logic             slot_free;
   lvse_mul_req_type mul_req;
   lvse_mul_rsp_type mul_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLY_ORDER:  cfg_in.poly_order = csr_wr_data[ORDER_W-1:0];
            CSR_DILATION:    cfg_in.dilation = $signed(csr_wr_data);
            CSR_TRANSLATION: cfg_in.translation = $signed(csr_wr_data);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (seq_res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = seq_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poly_order <= '0;
         cfg_ff.dilation <= 32'sd65536;
         cfg_ff.translation <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   lvse_sequencer #(
      .MAX_ORDER(MAX_ORDER)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample_x  ($signed(req_tdata)),
      .cfg       (cfg_ff),
      .res_valid (seq_res_valid),
      .res_ready (slot_free),
      .result    (seq_result),
      .mul_req   (mul_req),
      .mul_rsp   (mul_rsp)
   );

   lvse_mul_unit u_mul_unit (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_data_ff.poly_slope, rsp_data_ff.poly_value};
   assign rsp_tuser = rsp_data_ff.out_of_range;

endmodule
